@@ design/pdfp_pkg.sv @@
// Shared types, codes and helpers for the phasor data frame parser.
// No dependencies; used by pdfp_parser, pdfp_out_queue and the top level.
`default_nettype none

package pdfp_pkg;

  // Clamp limits applied to the configured counts.
  localparam int MaxPhasors = 16;
  localparam int MaxAnalogs = 16;

  localparam logic [7:0]  SYNC_BYTE0      = 8'hAA;
  localparam logic [7:0]  SYNC_BYTE1      = 8'h01;
  localparam logic [30:0] FREQ_LIMIT_BITS  = 31'h3A83126F;  // 0.001f
  localparam logic [30:0] ROCOF_LIMIT_BITS = 31'h358637BD;  // 0.000001f
  localparam logic [30:0] FLOAT_INF_BITS   = 31'h7F800000;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'h1021;

  // Configuration register indexes.
  localparam logic [1:0] REG_PHASOR_COUNT = 2'd0;
  localparam logic [1:0] REG_ANALOG_COUNT = 2'd1;
  localparam logic [1:0] REG_VOLTAGE_MASK = 2'd2;

  typedef enum logic [3:0] {
    KIND_ID      = 4'd0,
    KIND_SOC     = 4'd1,
    KIND_FRACSEC = 4'd2,
    KIND_MAG     = 4'd3,
    KIND_ANGLE   = 4'd4,
    KIND_FREQ    = 4'd5,
    KIND_ROCOF   = 4'd6,
    KIND_ANALOG  = 4'd7,
    KIND_STATUS  = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_SYNC  = 3'd2,
    ST_CRC       = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  typedef struct packed {
    logic [4:0]  phasor_count;
    logic [4:0]  analog_count;
    logic [15:0] voltage_mask;
  } cfg_t;

  // Results caused by one byte: an optional field item, then an optional status item.
  typedef struct packed {
    logic        fvalid;
    kind_t       kind;
    logic [3:0]  idx;
    logic [31:0] value;
    logic        flag;
    logic        svalid;
    status_t     status;
  } entry_t;

  // One byte step of CRC-CCITT, MSB first.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // |float| above limit, NaN excluded.
  function automatic logic above(input logic [31:0] bits, input logic [30:0] limit);
    return (bits[30:0] > limit) && (bits[30:0] <= FLOAT_INF_BITS);
  endfunction

endpackage

`default_nettype wire

@@ design/phasor_data_frame_parser.sv @@
// A byte's results are registered in the result queue before reaching the master side.
// One byte per cycle while the result queue has space; a byte that gives a field and
//   a status leaves as two items via the two-entry queue (ready drops while it is full).
// Reset (rst, synchronous): frame state to start of frame, CRC to 0xFFFF, queue empty,
//   phasor/analog counts to 0, voltage mask to all ones.
`default_nettype none

module phasor_data_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] data_byte
  input  wire logic        s_tlast,    // end_of_frame
  // result items out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,    // [3:0] element_index, [35:4] field_value,
                                       // [36] field_flag, [39:37] frame_status
  output logic [3:0]       m_tuser,    // [3:0] item_kind
  output logic             m_tlast,    // last_of_run
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  pdfp_pkg::cfg_t   cfg;
  pdfp_pkg::entry_t entry;
  logic             push;
  logic             space;
  logic             accept;

  // Config registers take a write in any cycle; index 3 is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phasor_count <= '0;
      cfg.analog_count <= '0;
      cfg.voltage_mask <= 16'hFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pdfp_pkg::REG_PHASOR_COUNT: cfg.phasor_count <= cfg_data[4:0];
        pdfp_pkg::REG_ANALOG_COUNT: cfg.analog_count <= cfg_data[4:0];
        pdfp_pkg::REG_VOLTAGE_MASK: cfg.voltage_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // A word is taken whenever the result queue can hold its entry.
  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;

  // Decode: field items complete on their last big-endian byte, status on end of frame.
  pdfp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (s_tdata),
    .end_of_frame (s_tlast),
    .cfg          (cfg),
    .entry        (entry),
    .push         (push)
  );

  // Result register and skid: field item goes out before the status item.
  pdfp_out_queue u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .entry    (entry),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ design/pdfp_parser.sv @@
// Frame state and per-byte field/status decode for the phasor data frame parser.
// Depends on pdfp_pkg.
`default_nettype none

module pdfp_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_frame,
  input  wire pdfp_pkg::cfg_t  cfg,
  output pdfp_pkg::entry_t     entry,
  output logic                 push
);

  logic [15:0] byte_position;
  logic [31:0] field_shift;
  logic [15:0] running_crc;
  logic [15:0] crc_byte_delay;
  logic        sync_good;

  logic        sync_next;
  logic [15:0] crc_next;
  logic [15:0] delay_next;
  logic [31:0] shift_next;
  logic [4:0]  eff_ph;
  logic [4:0]  eff_an;
  logic [15:0] off;
  logic [15:0] off_a;
  logic [15:0] off_b;
  logic [15:0] pb;
  logic [4:0]  ph;
  logic [16:0] len;
  logic [16:0] need;

  always_comb begin
    eff_ph = (32'(cfg.phasor_count) > pdfp_pkg::MaxPhasors) ?
             5'(pdfp_pkg::MaxPhasors) : cfg.phasor_count;
    eff_an = (32'(cfg.analog_count) > pdfp_pkg::MaxAnalogs) ?
             5'(pdfp_pkg::MaxAnalogs) : cfg.analog_count;

    sync_next = sync_good;
    if (byte_position == 16'd0 && data_byte != pdfp_pkg::SYNC_BYTE0) sync_next = 1'b0;
    if (byte_position == 16'd1 && data_byte != pdfp_pkg::SYNC_BYTE1) sync_next = 1'b0;
    // CRC runs two bytes behind so the trailing CRC field is left out
    crc_next   = (byte_position >= 16'd2) ?
                 pdfp_pkg::crc_step(running_crc, crc_byte_delay[15:8]) : running_crc;
    delay_next = {crc_byte_delay[7:0], data_byte};
    shift_next = {field_shift[23:0], data_byte};

    pb    = {8'd0, eff_ph, 3'b000};
    off   = byte_position - 16'd16;
    off_a = off - pb;
    off_b = off_a - 16'd8;
    ph    = off[7:3];

    entry        = '0;
    entry.kind   = pdfp_pkg::KIND_ID;
    entry.value  = shift_next;
    entry.status = pdfp_pkg::ST_OK;

    if (byte_position == 16'd5) begin
      entry.fvalid = 1'b1;
      entry.value  = {16'd0, shift_next[15:0]};
    end else if (byte_position == 16'd9) begin
      entry.fvalid = 1'b1;
      entry.kind   = pdfp_pkg::KIND_SOC;
    end else if (byte_position == 16'd13) begin
      entry.fvalid = 1'b1;
      entry.kind   = pdfp_pkg::KIND_FRACSEC;
    end else if (byte_position >= 16'd16) begin
      if (off < pb) begin
        if (off[1:0] == 2'b11) begin
          entry.fvalid = 1'b1;
          entry.kind   = off[2] ? pdfp_pkg::KIND_ANGLE : pdfp_pkg::KIND_MAG;
          entry.idx    = ph[3:0];
          entry.flag   = ph[4] ? 1'b1 : cfg.voltage_mask[ph[3:0]];
        end
      end else if (off_a < 16'd8) begin
        if (off_a == 16'd3) begin
          entry.fvalid = 1'b1;
          entry.kind   = pdfp_pkg::KIND_FREQ;
          entry.flag   = pdfp_pkg::above(shift_next, pdfp_pkg::FREQ_LIMIT_BITS);
        end else if (off_a == 16'd7) begin
          entry.fvalid = 1'b1;
          entry.kind   = pdfp_pkg::KIND_ROCOF;
          entry.flag   = pdfp_pkg::above(shift_next, pdfp_pkg::ROCOF_LIMIT_BITS);
        end
      end else if (off_b < {9'd0, eff_an, 2'b00} && off_b[1:0] == 2'b11) begin
        entry.fvalid = 1'b1;
        entry.kind   = pdfp_pkg::KIND_ANALOG;
        entry.idx    = off_b[5:2];
      end
    end

    len  = {1'b0, byte_position} + 17'd1;
    need = 17'd24 + {9'd0, eff_ph, 3'b000} + {10'd0, eff_an, 2'b00};
    entry.svalid = end_of_frame;
    if (byte_position < 16'd15)     entry.status = pdfp_pkg::ST_SHORT;
    else if (!sync_next)            entry.status = pdfp_pkg::ST_BAD_SYNC;
    else if (crc_next != delay_next) entry.status = pdfp_pkg::ST_CRC;
    else if (len < need)            entry.status = pdfp_pkg::ST_TRUNCATED;
    else                            entry.status = pdfp_pkg::ST_OK;

    push = accept && (entry.fvalid || entry.svalid);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_frame)) begin
      byte_position  <= '0;
      field_shift    <= '0;
      running_crc    <= pdfp_pkg::CRC_INIT;
      crc_byte_delay <= '0;
      sync_good      <= 1'b1;
    end else if (accept) begin
      if (byte_position != 16'hFFFF) byte_position <= byte_position + 16'd1;
      field_shift    <= shift_next;
      running_crc    <= crc_next;
      crc_byte_delay <= delay_next;
      sync_good      <= sync_next;
    end
  end

`ifndef SYNTHESIS
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_frame |=> byte_position == 16'd0 && running_crc == pdfp_pkg::CRC_INIT)
    else $error("frame state not cleared after end of frame");
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(byte_position) && $stable(running_crc))
    else $error("frame state moved without an accepted word");
  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    accept && !end_of_frame && byte_position == 16'hFFFF |=> byte_position == 16'hFFFF)
    else $error("byte position wrapped on a long frame");
`endif

endmodule

`default_nettype wire

@@ design/pdfp_out_queue.sv @@
// Two-entry result queue; splits an entry into its field and status items.
// Depends on pdfp_pkg.
`default_nettype none

module pdfp_out_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire pdfp_pkg::entry_t  entry,
  output logic                   space,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [39:0]            m_tdata,
  output logic [3:0]             m_tuser,
  output logic                   m_tlast
);

  pdfp_pkg::entry_t q0;
  pdfp_pkg::entry_t q1;
  logic [1:0]       count;
  logic             pop_item;
  logic             pop_entry;
  logic [1:0]       count_after_pop;

  assign space     = (count != 2'd2);
  assign m_tvalid  = (count != 2'd0);
  assign pop_item  = m_tvalid && m_tready;
  assign pop_entry = pop_item && !(q0.fvalid && q0.svalid);
  assign count_after_pop = count - {1'b0, pop_entry};

  always_comb begin
    if (q0.fvalid) begin
      m_tuser = 4'(q0.kind);
      m_tdata = {3'(pdfp_pkg::ST_OK), q0.flag, q0.value, q0.idx};
      m_tlast = !q0.svalid;
    end else begin
      m_tuser = 4'(pdfp_pkg::KIND_STATUS);
      m_tdata = {3'(q0.status), 1'b0, 32'd0, 4'd0};
      m_tlast = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_after_pop + {1'b0, push};
    end
    if (push && count_after_pop == 2'd0) begin
      q0 <= entry;
    end else if (pop_entry) begin
      q0 <= q1;
    end else if (pop_item) begin
      q0.fvalid <= 1'b0;  // field item gone, status item stays
    end
    if (push && count_after_pop != 2'd0) begin
      q1 <= entry;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue overfilled");
  a_head_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (q0.fvalid || q0.svalid))
    else $error("queue head carries no item");
  a_split_status: assert property (@(posedge clk) disable iff (rst)
    pop_item && q0.fvalid && q0.svalid |=> m_tvalid && m_tuser == 4'(pdfp_pkg::KIND_STATUS))
    else $error("status item lost after its field item");
`endif

endmodule

`default_nettype wire
